// File: hw/rtl/version_string_parser_core_defines.svh
// Assertion helpers for the version string parser core.
`ifndef VERSION_STRING_PARSER_CORE_DEFINES_SVH
`define VERSION_STRING_PARSER_CORE_DEFINES_SVH

// Check a condition on every rising clock edge outside reset.
`define VSP_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define VSP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define VSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vsp_pkg.sv
`timescale 1ns / 1ps

package vsp_pkg;

    // Pre-release text storage
    localparam int PRE_DEPTH      = 32;
    localparam int PRE_AW         = 5;
    localparam int PRE_CW         = 6;
    localparam int PRERELEASE_MAX = 32;
    localparam int PRE_LIMIT_INT  = (PRERELEASE_MAX < PRE_DEPTH) ? PRERELEASE_MAX : PRE_DEPTH;
    localparam logic [PRE_CW-1:0] PRE_LIMIT = PRE_CW'(PRE_LIMIT_INT);

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Commands from controller to datapath
    typedef struct packed {
        logic acc_major;
        logic acc_minor;
        logic acc_patch;
        logic set_digit;
        logic clr_digit;
        logic set_pre;
        logic store_pre;
        logic set_bad;
        logic rd_issue;
        logic load_out;
        logic next_idx;
        logic clr_all;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_ws;
        logic is_dot;
        logic is_dash;
        logic is_plus;
        logic is_nul;
        logic digit_seen;
        logic bad;
        logic pre_full;
        logic run_last;
        logic out_free;
    } t_stat;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: hw/rtl/vsp_ctrl.sv
`timescale 1ns / 1ps

module vsp_ctrl
    import vsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_end_mark,
    input  t_stat i_stat,
    output logic o_stall,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_LEAD    = 4'd0;
    localparam logic [3:0] S_MAJOR   = 4'd1;
    localparam logic [3:0] S_MINOR   = 4'd2;
    localparam logic [3:0] S_PATCH   = 4'd3;
    localparam logic [3:0] S_PRE     = 4'd4;
    localparam logic [3:0] S_BUILD   = 4'd5;
    localparam logic [3:0] S_TRAIL   = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;
    localparam logic [3:0] S_EMIT_RD = 4'd8;
    localparam logic [3:0] S_EMIT_LD = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_in_acc;
    logic       w_end_ok;

    // Hold the input while a result run is being sent
    assign o_stall  = (r_state == S_EMIT_RD) || (r_state == S_EMIT_LD);
    assign w_in_acc = i_valid && !o_stall;

    // Decide whether the string may end here
    always_comb begin
        unique case (r_state)
            S_LEAD, S_MAJOR, S_MINOR: w_end_ok = 1'b0;
            S_PATCH:                  w_end_ok = i_stat.digit_seen;
            default:                  w_end_ok = 1'b1;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_EMIT_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.run_last) begin
                        o_cmd.clr_all = 1'b1;
                        n_state       = S_LEAD;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            default: begin
                if (w_in_acc) begin
                    if (i_end_mark) begin
                        o_cmd.set_bad = !w_end_ok;
                        n_state       = S_EMIT_RD;
                    end else if (i_stat.bad || (r_state == S_DONE)) begin
                        n_state = r_state;
                    end else if (i_stat.is_nul) begin
                        o_cmd.set_bad = !w_end_ok;
                        n_state       = S_DONE;
                    end else begin
                        case (r_state)
                            S_LEAD: begin
                                if (i_stat.is_digit) begin
                                    o_cmd.acc_major = 1'b1;
                                    o_cmd.set_digit = 1'b1;
                                    n_state         = S_MAJOR;
                                end else if (!i_stat.is_ws) begin
                                    o_cmd.set_bad = 1'b1;
                                end
                            end
                            S_MAJOR, S_MINOR: begin
                                if (i_stat.is_digit) begin
                                    o_cmd.acc_major = (r_state == S_MAJOR);
                                    o_cmd.acc_minor = (r_state == S_MINOR);
                                    o_cmd.set_digit = 1'b1;
                                end else if (i_stat.is_dot && i_stat.digit_seen) begin
                                    o_cmd.clr_digit = 1'b1;
                                    n_state = (r_state == S_MAJOR) ? S_MINOR : S_PATCH;
                                end else begin
                                    o_cmd.set_bad = 1'b1;
                                end
                            end
                            S_PATCH: begin
                                if (i_stat.is_digit) begin
                                    o_cmd.acc_patch = 1'b1;
                                    o_cmd.set_digit = 1'b1;
                                end else if (!i_stat.digit_seen) begin
                                    o_cmd.set_bad = 1'b1;
                                end else if (i_stat.is_dash) begin
                                    o_cmd.set_pre = 1'b1;
                                    n_state       = S_PRE;
                                end else if (i_stat.is_plus) begin
                                    n_state = S_BUILD;
                                end else if (i_stat.is_ws) begin
                                    n_state = S_TRAIL;
                                end else begin
                                    o_cmd.set_bad = 1'b1;
                                end
                            end
                            S_PRE: begin
                                if (i_stat.is_plus) begin
                                    n_state = S_BUILD;
                                end else if (i_stat.pre_full) begin
                                    o_cmd.set_bad = 1'b1;
                                end else begin
                                    o_cmd.store_pre = 1'b1;
                                end
                            end
                            S_BUILD: begin
                                if (i_stat.is_ws) begin
                                    n_state = S_TRAIL;
                                end
                            end
                            S_TRAIL: begin
                                o_cmd.set_bad = !i_stat.is_ws;
                            end
                            default: begin
                                n_state = r_state;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LEAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/vsp_datapath.sv
`timescale 1ns / 1ps

module vsp_datapath
    import vsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_ch,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic        o_valid_res,
    output logic [63:0] o_major_value,
    output logic [63:0] o_minor_value,
    output logic [63:0] o_patch_value,
    output logic        o_has_prerelease,
    output logic [5:0]  o_prerelease_length,
    output logic [4:0]  o_char_position,
    output logic [7:0]  o_pre_char,
    output logic        o_run_last
);

    logic [63:0]       r_major;
    logic [63:0]       r_minor;
    logic [63:0]       r_patch;
    logic              r_digit_seen;
    logic              r_pre_present;
    logic [PRE_CW-1:0] r_pre_count;
    logic              r_bad;
    logic [PRE_AW-1:0] r_idx;
    logic [7:0]        r_mem [PRE_DEPTH];
    logic [7:0]        r_rdata;
    logic              r_out_valid;
    logic [63:0]       w_acc_in;
    logic [63:0]       w_acc_out;
    logic              w_last;

    // Multiply by ten as two shifts, then add the digit
    function automatic logic [63:0] acc_digit(input logic [63:0] a, input logic [3:0] d);
        return {a[60:0], 3'b000} + {a[62:0], 1'b0} + {60'd0, d};
    endfunction

    // Share one accumulate adder among the three fields
    always_comb begin
        case (1'b1)
            i_cmd.acc_minor: w_acc_in = r_minor;
            i_cmd.acc_patch: w_acc_in = r_patch;
            default:         w_acc_in = r_major;
        endcase
    end
    assign w_acc_out = acc_digit(w_acc_in, i_ch[3:0]);

    assign w_last = r_bad || (r_pre_count == '0)
                    || ({1'b0, r_idx} == (r_pre_count - PRE_CW'(1)));

    // Report character class and flags
    always_comb begin
        o_stat.is_digit   = is_digit(i_ch);
        o_stat.is_ws      = is_ws(i_ch);
        o_stat.is_dot     = (i_ch == CH_DOT);
        o_stat.is_dash    = (i_ch == CH_DASH);
        o_stat.is_plus    = (i_ch == CH_PLUS);
        o_stat.is_nul     = (i_ch == CH_NUL);
        o_stat.digit_seen = r_digit_seen;
        o_stat.bad        = r_bad;
        o_stat.pre_full   = (r_pre_count >= PRE_LIMIT);
        o_stat.run_last   = w_last;
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_major       <= '0;
            r_minor       <= '0;
            r_patch       <= '0;
            r_digit_seen  <= 1'b0;
            r_pre_present <= 1'b0;
            r_pre_count   <= '0;
            r_bad         <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (i_cmd.acc_major) r_major <= w_acc_out;
            if (i_cmd.acc_minor) r_minor <= w_acc_out;
            if (i_cmd.acc_patch) r_patch <= w_acc_out;
            if (i_cmd.set_digit) r_digit_seen <= 1'b1;
            if (i_cmd.clr_digit) r_digit_seen <= 1'b0;
            if (i_cmd.set_pre) r_pre_present <= 1'b1;
            if (i_cmd.store_pre) r_pre_count <= r_pre_count + PRE_CW'(1);
            if (i_cmd.set_bad) r_bad <= 1'b1;
            if (i_cmd.next_idx) r_idx <= r_idx + PRE_AW'(1);
        end
    end

    // Pre-release text buffer, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pre) begin
            r_mem[r_pre_count[PRE_AW-1:0]] <= i_ch;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload; an invalid string gives an all-zero word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_bad) begin
                o_valid_res         <= 1'b0;
                o_major_value       <= '0;
                o_minor_value       <= '0;
                o_patch_value       <= '0;
                o_has_prerelease    <= 1'b0;
                o_prerelease_length <= '0;
                o_char_position     <= '0;
                o_pre_char          <= '0;
            end else begin
                o_valid_res         <= 1'b1;
                o_major_value       <= r_major;
                o_minor_value       <= r_minor;
                o_patch_value       <= r_patch;
                o_has_prerelease    <= r_pre_present;
                o_prerelease_length <= r_pre_count;
                o_char_position     <= r_idx;
                o_pre_char          <= (r_pre_count == '0) ? 8'd0 : r_rdata;
            end
            o_run_last <= w_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: hw/rtl/version_string_parser_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | i_valid / o_stall  | i_ch, i_end_mark
// output    | o_valid / i_stall  | o_valid_res, o_major_value, o_minor_value,
//           |                    | o_patch_value, o_has_prerelease,
//           |                    | o_prerelease_length, o_char_position,
//           |                    | o_pre_char, o_run_last
//
// A character is accumulated by the shared multiply-by-ten adder as it is
// accepted. An end marker starts a run of max(1, pre-release length) result
// words; each is a registered buffer read, then an output load that waits on
// output stall. The input is stalled for the run and reopens once the final
// word is loaded. Reset is synchronous and active low; no clearing pass.

`include "version_string_parser_core_defines.svh"

module version_string_parser_core
    import vsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_mark,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [63:0] o_major_value,
    output logic [63:0] o_minor_value,
    output logic [63:0] o_patch_value,
    output logic        o_has_prerelease,
    output logic [5:0]  o_prerelease_length,
    output logic [4:0]  o_char_position,
    output logic [7:0]  o_pre_char,
    output logic        o_run_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    vsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_end_mark (i_end_mark),
        .i_stat     (w_stat),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd)
    );

    vsp_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ch                (i_ch),
        .i_stall             (i_stall),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_valid             (o_valid),
        .o_valid_res         (o_valid_res),
        .o_major_value       (o_major_value),
        .o_minor_value       (o_minor_value),
        .o_patch_value       (o_patch_value),
        .o_has_prerelease    (o_has_prerelease),
        .o_prerelease_length (o_prerelease_length),
        .o_char_position     (o_char_position),
        .o_pre_char          (o_pre_char),
        .o_run_last          (o_run_last)
    );

    // Never overwrite a word that is still waiting
    `VSP_ASSERT_IMPL(a_load_free, w_cmd.load_out, w_stat.out_free, "output word overwritten")

    // Input reopens right after the final word of a run is loaded
    `VSP_ASSERT_NEXT(a_reopen, w_cmd.load_out && w_stat.run_last, !o_stall, "input not reopened")

    // An invalid word is a single all-zero word
    `VSP_ASSERT_IMPL(a_bad_zero, o_valid && !o_valid_res, o_run_last && (o_major_value == '0) && (o_minor_value == '0) && (o_patch_value == '0) && !o_has_prerelease && (o_prerelease_length == '0) && (o_pre_char == '0), "invalid word not cleared")

    // Without pre-release characters the run is one word at position zero
    `VSP_ASSERT_IMPL(a_empty_pre, o_valid && o_valid_res && (o_prerelease_length == '0), o_run_last && (o_char_position == '0) && (o_pre_char == '0), "empty pre-release run")

endmodule

// File: verif/tb_version_string_parser_core.sv
`timescale 1ns / 1ps

module tb_version_string_parser_core;
    import vsp_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 60;
    localparam int END_SETTLE   = 20;

    typedef enum logic [3:0] {
        P_LEAD, P_MAJOR, P_MINOR, P_PATCH, P_PRE, P_BUILD, P_TRAIL, P_DONE
    } t_parse_phase;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] major;
        logic [63:0] minor;
        logic [63:0] patch;
        logic        has_pre;
        logic [5:0]  pre_len;
        logic [4:0]  pos;
        logic [7:0]  pre_char;
        logic        run_last;
    } t_version_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        i_end_mark;
    logic        o_valid;
    logic        i_stall;
    logic        o_valid_res;
    logic [63:0] o_major_value;
    logic [63:0] o_minor_value;
    logic [63:0] o_patch_value;
    logic        o_has_prerelease;
    logic [5:0]  o_prerelease_length;
    logic [4:0]  o_char_position;
    logic [7:0]  o_pre_char;
    logic        o_run_last;

    // Parser shadow state
    t_parse_phase ps_phase;
    logic [63:0]  ps_major;
    logic [63:0]  ps_minor;
    logic [63:0]  ps_patch;
    logic         ps_digit;
    logic         ps_pre;
    int           ps_count;
    logic [7:0]   ps_text [PRE_DEPTH];
    logic         ps_bad;

    t_version_word expected_words[$];
    logic [7:0]    str_bytes[$];
    int            error_count = 0;
    int            items_sent  = 0;
    int            idle_cycles = 0;
    logic          calm        = 1'b0;

    always #2 i_clk = ~i_clk;

    version_string_parser_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_ch               (i_ch),
        .i_end_mark         (i_end_mark),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_valid_res        (o_valid_res),
        .o_major_value      (o_major_value),
        .o_minor_value      (o_minor_value),
        .o_patch_value      (o_patch_value),
        .o_has_prerelease   (o_has_prerelease),
        .o_prerelease_length(o_prerelease_length),
        .o_char_position    (o_char_position),
        .o_pre_char         (o_pre_char),
        .o_run_last         (o_run_last)
    );

    // ---------------------------------------------------------------- predictor

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [63:0] push_digit(input logic [63:0] acc, input logic [7:0] c);
        return acc * 64'd10 + 64'(c - CH_ZERO);
    endfunction

    // A string may stop here only once a patch digit has been read
    function automatic logic end_allowed();
        case (ps_phase)
            P_LEAD, P_MAJOR, P_MINOR: return 1'b0;
            P_PATCH:                  return ps_digit;
            default:                  return 1'b1;
        endcase
    endfunction

    task automatic clear_parser();
        ps_phase = P_LEAD;
        ps_major = '0;
        ps_minor = '0;
        ps_patch = '0;
        ps_digit = 1'b0;
        ps_pre   = 1'b0;
        ps_count = 0;
        ps_bad   = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c);
        case (ps_phase)
            P_LEAD: begin
                if (digit_char(c)) begin
                    ps_major = push_digit(ps_major, c);
                    ps_digit = 1'b1;
                    ps_phase = P_MAJOR;
                end else if (!blank_char(c)) begin
                    ps_bad = 1'b1;
                end
            end
            P_MAJOR, P_MINOR: begin
                if (digit_char(c)) begin
                    if (ps_phase == P_MAJOR) ps_major = push_digit(ps_major, c);
                    else ps_minor = push_digit(ps_minor, c);
                    ps_digit = 1'b1;
                end else if (c == CH_DOT && ps_digit) begin
                    ps_digit = 1'b0;
                    ps_phase = (ps_phase == P_MAJOR) ? P_MINOR : P_PATCH;
                end else begin
                    ps_bad = 1'b1;
                end
            end
            P_PATCH: begin
                if (digit_char(c)) begin
                    ps_patch = push_digit(ps_patch, c);
                    ps_digit = 1'b1;
                end else if (!ps_digit) begin
                    ps_bad = 1'b1;
                end else if (c == CH_DASH) begin
                    ps_pre   = 1'b1;
                    ps_phase = P_PRE;
                end else if (c == CH_PLUS) begin
                    ps_phase = P_BUILD;
                end else if (blank_char(c)) begin
                    ps_phase = P_TRAIL;
                end else begin
                    ps_bad = 1'b1;
                end
            end
            // Store everything up to '+', whitespace included
            P_PRE: begin
                if (c == CH_PLUS) begin
                    ps_phase = P_BUILD;
                end else if (ps_count >= PRE_LIMIT_INT) begin
                    ps_bad = 1'b1;
                end else begin
                    ps_text[ps_count] = c;
                    ps_count++;
                end
            end
            P_BUILD: if (blank_char(c)) ps_phase = P_TRAIL;
            P_TRAIL: if (!blank_char(c)) ps_bad = 1'b1;
            default: ;
        endcase
    endtask

    // Advance the shadow parser by one word and, on an end marker, queue the run it produces
    task automatic predict_word(input logic [7:0] c, input logic em);
        t_version_word w;
        int            n;
        if (!em) begin
            if (!ps_bad && ps_phase != P_DONE) begin
                if (c == CH_NUL) begin
                    if (!end_allowed()) ps_bad = 1'b1;
                    ps_phase = P_DONE;
                end else begin
                    take_char(c);
                end
            end
        end else begin
            if (!end_allowed()) ps_bad = 1'b1;
            if (ps_bad) begin
                w          = '0;
                w.run_last = 1'b1;
                expected_words.push_back(w);
            end else begin
                n = (ps_count == 0) ? 1 : ps_count;
                for (int k = 0; k < n; k++) begin
                    w.valid_res = 1'b1;
                    w.major     = ps_major;
                    w.minor     = ps_minor;
                    w.patch     = ps_patch;
                    w.has_pre   = ps_pre;
                    w.pre_len   = 6'(ps_count);
                    w.pos       = 5'(k);
                    w.pre_char  = (ps_count == 0) ? 8'h00 : ps_text[k];
                    w.run_last  = (k == n - 1);
                    expected_words.push_back(w);
                end
            end
            clear_parser();
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_words
        t_version_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_error("result word with no expectation pending");
            end else begin
                want = expected_words.pop_front();
                check_field("valid_res", o_valid_res, want.valid_res);
                check_field("major_value", o_major_value, want.major);
                check_field("minor_value", o_minor_value, want.minor);
                check_field("patch_value", o_patch_value, want.patch);
                check_field("has_prerelease", o_has_prerelease, want.has_pre);
                check_field("prerelease_length", o_prerelease_length, want.pre_len);
                check_field("char_position", o_char_position, want.pos);
                check_field("pre_char", o_pre_char, want.pre_char);
                check_field("run_last", o_run_last, want.run_last);
            end
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_version_string_parser_core failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: hold stall for a random number of cycles before each word
    initial begin : drive_stall
        int gap;
        i_stall = 1'b0;
        forever begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_word(input logic [7:0] c, input logic em);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_ch       <= c;
        i_end_mark <= em;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_word(c, em);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send the staged string, then an end marker with a random dummy byte
    task automatic run_string();
        foreach (str_bytes[i]) send_word(str_bytes[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
    endtask

    task automatic run_text(input string s);
        str_bytes.delete();
        add_text(s);
        run_string();
    endtask

    // Drop valid and hold off until every expected word has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    // Any pre-release byte that neither ends the text nor the string
    function automatic logic [7:0] pre_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_PLUS);
        return c;
    endfunction

    task automatic add_number();
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 3);
        repeat (len) str_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic test_well_formed();
        run_text("0.0.0");
        run_text("1.2.3-alpha.1+build.5");
        run_text("18446744073709551615.18446744073709551616.99999999999999999999");
        run_text("4.5.6-rc 1+meta.x \t");
        run_text("1.2.3-");
        run_text("7.0.1+");
        // every whitespace byte around the version
        str_bytes.delete();
        str_bytes.push_back(CH_SPACE);
        for (int c = CH_TAB; c <= CH_CR; c++) str_bytes.push_back(8'(c));
        add_text("7.8.9");
        for (int c = CH_CR; c >= CH_TAB; c--) str_bytes.push_back(8'(c));
        run_string();
        // high bytes in pre-release and build text
        str_bytes.delete();
        add_text("9.9.9-");
        str_bytes.push_back(8'hFF);
        str_bytes.push_back(8'h80);
        str_bytes.push_back(8'h7F);
        str_bytes.push_back(8'h01);
        add_text("+");
        str_bytes.push_back(8'hFE);
        run_string();
    endtask

    task automatic test_malformed();
        run_text("");
        run_text("  \t ");
        run_text("1.2");
        run_text("1..3");
        run_text("v1.2.3");
        run_text("1.2.3x");
        run_text("1.2.3 4");
        run_text("1.2.3+b c");
        run_text("1.2.");
    endtask

    task automatic test_zero_byte();
        str_bytes.delete();
        add_text("1.2.3-ab");
        str_bytes.push_back(CH_NUL);
        add_text("zz");
        run_string();
        str_bytes.delete();
        add_text("1.2");
        str_bytes.push_back(CH_NUL);
        add_text(".3");
        run_string();
        str_bytes.delete();
        str_bytes.push_back(CH_NUL);
        run_string();
    endtask

    task automatic test_prerelease_limit();
        // full buffer, one byte over, and full buffer followed by build text
        for (int extra = 0; extra < 3; extra++) begin
            str_bytes.delete();
            add_text("1.0.0-");
            repeat (PRE_LIMIT_INT + (extra == 1)) str_bytes.push_back(pre_byte());
            if (extra == 2) add_text("+b");
            run_string();
        end
    endtask

    task automatic test_random_strings();
        int start_items;
        int mode;
        int len;
        int idx;
        start_items = items_sent;
        idx = 0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            calm = (idx % 6 == 0);
            // hold off until the run still in flight has fully drained
            if (idx == 0) wait_drained();
            str_bytes.delete();
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                // pure noise
                repeat ($urandom_range(0, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 2)) str_bytes.push_back(blank_byte());
                add_number();
                str_bytes.push_back(CH_DOT);
                add_number();
                str_bytes.push_back(CH_DOT);
                add_number();
                if ($urandom_range(0, 1) == 1) begin
                    str_bytes.push_back(CH_DASH);
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 34)
                                                      : $urandom_range(0, 6);
                    repeat (len) str_bytes.push_back(pre_byte());
                end
                if ($urandom_range(0, 2) == 0) begin
                    str_bytes.push_back(CH_PLUS);
                    repeat ($urandom_range(0, 4))
                        str_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) str_bytes.push_back(blank_byte());
                // break one byte, or cut the string short with a zero byte
                if (mode == 7)
                    str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                if (mode == 8) begin
                    str_bytes.insert($urandom_range(0, str_bytes.size()), CH_NUL);
                    repeat ($urandom_range(0, 3))
                        str_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            run_string();
            idx++;
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ch       = 8'h00;
        i_end_mark = 1'b0;
        clear_parser();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_well_formed();
        test_malformed();
        test_zero_byte();
        test_prerelease_limit();
        test_random_strings();

        wait_drained();
        repeat (END_SETTLE) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb_version_string_parser_core passed");
        end else begin
            $display("tb_version_string_parser_core failed");
        end
        $finish;
    end

endmodule

// File: version_string_parser_core.f
+incdir+hw/rtl
hw/rtl/vsp_pkg.sv
hw/rtl/vsp_ctrl.sv
hw/rtl/vsp_datapath.sv
hw/rtl/version_string_parser_core.sv
verif/tb_version_string_parser_core.sv
